FILE: rtl/prs_pkg.sv
package prs_pkg;

   // fixed field widths
   localparam int CMD_BITS        = 2;
   localparam int COEF_BITS       = 16;
   localparam int COEF_INDEX_BITS = 4;
   localparam int RAMP_BITS       = 16;
   localparam int SETTLE_BITS     = 20;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 20;

   // input commands
   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK       = 2'd0,
      CMD_SET_TARGET = 2'd1,
      CMD_JUMP       = 2'd2,
      CMD_RESTART    = 2'd3
   } command_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODE         = 2'd0,
      CSR_RAMP_STEPS   = 2'd1,
      CSR_DECAY_COEF   = 2'd2,
      CSR_SETTLE_STEPS = 2'd3
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_ABS,
      ST_DIV,
      ST_FIX,
      ST_ADD,
      ST_OUT
   } state_type;

endpackage

FILE: rtl/parameter_ramp_smoother.sv
// channel   direction  handshake          payload
// req       in         req_valid/stall    req_command, req_value
// rsp       out        rsp_valid/stall    rsp_sample, rsp_smoothing, rsp_steps_left,
//                                         rsp_target_now
// csr       in         csr_write          csr_index, csr_wdata
//
// one transaction at a time; result shows the cycle after the work ends
// jump, restart, idle tick and exponential set target go straight to the result state;
// linear tick adds the slope once; exponential tick runs 16 shift-add steps of the shared adder
// and then adds the step; linear set target forms the difference and its magnitude, then the slope
// through the restoring divide loop on the shared adder
// reset is synchronous; a stalled result holds and req_stall stays high meanwhile
module parameter_ramp_smoother #(
   parameter int VALUE_BITS          = 24,
   parameter int EXTRA_FRACTION_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [prs_pkg::CMD_BITS-1:0]           req_command,
   input  logic signed [VALUE_BITS-1:0]           req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [VALUE_BITS-1:0]           rsp_sample,
   output logic                                   rsp_smoothing,
   output logic [prs_pkg::SETTLE_BITS-1:0]        rsp_steps_left,
   output logic signed [VALUE_BITS-1:0]           rsp_target_now,
   input  logic                                   csr_write,
   input  logic [prs_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [prs_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import prs_pkg::*;

   localparam int ACC_BITS  = VALUE_BITS + EXTRA_FRACTION_BITS;
   localparam int DW        = (ACC_BITS + 2 > RAMP_BITS + 2) ? ACC_BITS + 2 : RAMP_BITS + 2;
   localparam int DIV_STEPS = ACC_BITS + 1;
   localparam int CNT_BITS  = ($clog2(DIV_STEPS) > COEF_INDEX_BITS) ?
                              $clog2(DIV_STEPS) : COEF_INDEX_BITS;
   localparam int REM_BITS  = RAMP_BITS + 1;
   localparam logic [CNT_BITS-1:0] LAST_DIV = CNT_BITS'(DIV_STEPS - 1);
   localparam logic [CNT_BITS-1:0] LAST_MUL = CNT_BITS'(COEF_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   // clamp a wide result to the accumulator range
   function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [DW-1:0] x);
      logic [DW-ACC_BITS:0] top;
      logic signed [ACC_BITS-1:0] r;
      top = x[DW-1:ACC_BITS-1];
      if (top == '0 || top == '1) begin
         r = x[ACC_BITS-1:0];
      end else if (x[DW-1]) begin
         r = ACC_MIN;
      end else begin
         r = ACC_MAX;
      end
      return r;
   endfunction

   state_type                     state_ff, state_in;
   logic                          mode_ff, mode_in;
   logic [RAMP_BITS-1:0]          ramp_ff, ramp_in;
   logic [COEF_BITS-1:0]          coef_ff, coef_in;
   logic [SETTLE_BITS-1:0]        settle_ff, settle_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [VALUE_BITS-1:0]  target_ff, target_in;
   logic signed [ACC_BITS-1:0]    slope_ff, slope_in;
   logic [SETTLE_BITS-1:0]        count_ff, count_in;
   logic                          stepped_ff, stepped_in;
   logic signed [DW-1:0]          work_ff, work_in;
   logic signed [DW-1:0]          delta_ff, delta_in;
   logic [ACC_BITS:0]             quo_ff, quo_in;
   logic [REM_BITS-1:0]           rem_ff, rem_in;
   logic                          neg_ff, neg_in;
   logic                          div_op_ff, div_op_in;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in;

   logic signed [DW-1:0]          alu_a, alu_b, alu_sum;
   logic                          alu_sub;
   logic [REM_BITS-1:0]           shifted;
   logic [SETTLE_BITS-1:0]        arm_count;
   command_type                   cmd;
   logic                          accept;

   assign cmd       = command_type'(req_command);
   assign accept    = req_valid && !req_stall;
   assign arm_count = mode_ff ? settle_ff : SETTLE_BITS'(ramp_ff);
   assign shifted   = {rem_ff[REM_BITS-2:0], quo_ff[ACC_BITS]};

   // shared adder
   assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

   // configuration writes
   always_comb begin
      mode_in   = mode_ff;
      ramp_in   = ramp_ff;
      coef_in   = coef_ff;
      settle_in = settle_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:         mode_in   = csr_wdata[0];
            CSR_RAMP_STEPS:   ramp_in   = csr_wdata[RAMP_BITS-1:0];
            CSR_DECAY_COEF:   coef_in   = csr_wdata[COEF_BITS-1:0];
            CSR_SETTLE_STEPS: settle_in = csr_wdata[SETTLE_BITS-1:0];
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_TICK: begin
                     if (count_ff == '0) begin
                        state_in = ST_OUT;
                     end else if (mode_ff) begin
                        state_in = ST_DIFF;
                     end else begin
                        state_in = ST_ADD;
                     end
                  end
                  CMD_SET_TARGET: begin
                     state_in = (!mode_ff && ramp_ff != '0) ? ST_DIFF : ST_OUT;
                  end
                  CMD_JUMP, CMD_RESTART: state_in = ST_OUT;
               endcase
            end
         end
         ST_DIFF: state_in = div_op_ff ? ST_ABS : ST_MUL;
         ST_MUL:  state_in = (cnt_ff == LAST_MUL) ? ST_ADD : ST_MUL;
         ST_ABS:  state_in = ST_DIV;
         ST_DIV:  state_in = (cnt_ff == LAST_DIV) ? ST_FIX : ST_DIV;
         ST_FIX:  state_in = ST_OUT;
         ST_ADD:  state_in = ST_OUT;
         ST_OUT:  state_in = rsp_stall ? ST_OUT : ST_IDLE;
      endcase
   end

   // datapath control and next values
   always_comb begin
      acc_in     = acc_ff;
      target_in  = target_ff;
      slope_in   = slope_ff;
      count_in   = count_ff;
      stepped_in = stepped_ff;
      work_in    = work_ff;
      delta_in   = delta_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      neg_in     = neg_ff;
      div_op_in  = div_op_ff;
      cnt_in     = cnt_ff;
      alu_a      = '0;
      alu_b      = '0;
      alu_sub    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               stepped_in = 1'b0;
               div_op_in  = (cmd == CMD_SET_TARGET);
               unique case (cmd)
                  CMD_TICK: begin
                     if (count_ff != '0) begin
                        stepped_in = 1'b1;
                        count_in   = count_ff - 1'b1;
                        work_in    = DW'(slope_ff);
                     end
                  end
                  CMD_SET_TARGET: begin
                     target_in = req_value;
                     count_in  = arm_count;
                     if (mode_ff || ramp_ff == '0) begin
                        slope_in = '0;
                     end
                  end
                  CMD_JUMP: begin
                     acc_in    = ACC_BITS'(req_value) <<< EXTRA_FRACTION_BITS;
                     target_in = req_value;
                     slope_in  = '0;
                     count_in  = arm_count;
                  end
                  CMD_RESTART: begin
                     acc_in   = ACC_BITS'(target_ff) <<< EXTRA_FRACTION_BITS;
                     slope_in = '0;
                     count_in = arm_count;
                  end
               endcase
            end
         end
         // difference between widened target and running value
         ST_DIFF: begin
            alu_a    = DW'(target_ff) <<< EXTRA_FRACTION_BITS;
            alu_b    = DW'(acc_ff);
            alu_sub  = 1'b1;
            delta_in = alu_sum;
            work_in  = '0;
            cnt_in   = '0;
         end
         // shift-add multiply by the coefficient, lsb first, floor at each shift
         ST_MUL: begin
            alu_a   = work_ff;
            alu_b   = coef_ff[cnt_ff[COEF_INDEX_BITS-1:0]] ? delta_ff : '0;
            work_in = alu_sum >>> 1;
            cnt_in  = cnt_ff + 1'b1;
         end
         // magnitude of the difference for the divider
         ST_ABS: begin
            alu_b   = delta_ff;
            alu_sub = 1'b1;
            neg_in  = delta_ff[DW-1];
            quo_in  = delta_ff[DW-1] ? alu_sum[ACC_BITS:0] : delta_ff[ACC_BITS:0];
            rem_in  = '0;
            cnt_in  = '0;
         end
         // restoring divide by ramp steps, one quotient bit per cycle
         ST_DIV: begin
            alu_a   = DW'(shifted);
            alu_b   = DW'(ramp_ff);
            alu_sub = 1'b1;
            if (!alu_sum[DW-1]) begin
               rem_in = alu_sum[REM_BITS-1:0];
               quo_in = {quo_ff[ACC_BITS-1:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[ACC_BITS-1:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         // restore the sign and clamp the slope
         ST_FIX: begin
            alu_a    = neg_ff ? '0 : DW'(quo_ff);
            alu_b    = neg_ff ? DW'(quo_ff) : '0;
            alu_sub  = neg_ff;
            slope_in = sat_acc(alu_sum);
         end
         // add the step to the running value
         ST_ADD: begin
            alu_a  = DW'(acc_ff);
            alu_b  = work_ff;
            acc_in = sat_acc(alu_sum);
         end
         ST_OUT: begin
         end
      endcase
   end

   // handshake and result outputs
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      rsp_valid      = (state_ff == ST_OUT);
      rsp_smoothing  = (count_ff != '0);
      rsp_steps_left = count_ff;
      rsp_target_now = target_ff;
      rsp_sample     = (stepped_ff || count_ff != '0) ?
                       acc_ff[ACC_BITS-1 -: VALUE_BITS] : target_ff;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mode_ff    <= 1'b0;
         ramp_ff    <= RAMP_BITS'(1);
         coef_ff    <= '0;
         settle_ff  <= '0;
         acc_ff     <= '0;
         target_ff  <= '0;
         slope_ff   <= '0;
         count_ff   <= '0;
         stepped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         ramp_ff    <= ramp_in;
         coef_ff    <= coef_in;
         settle_ff  <= settle_in;
         acc_ff     <= acc_in;
         target_ff  <= target_in;
         slope_ff   <= slope_in;
         count_ff   <= count_in;
         stepped_ff <= stepped_in;
      end
   end

   // work registers of the shared unit
   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      delta_ff  <= delta_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      div_op_ff <= div_op_in;
      cnt_ff    <= cnt_in;
   end

endmodule

FILE: tb/parameter_ramp_smoother_test.sv
module parameter_ramp_smoother_test;
   timeunit 1ns;
   timeprecision 1ps;

   import prs_pkg::*;

   localparam int VALUE_BITS          = 24;
   localparam int EXTRA_FRACTION_BITS = 16;
   localparam int LEVEL_BITS          = VALUE_BITS + EXTRA_FRACTION_BITS;
   localparam int CLOCK_PERIOD        = 20;
   localparam int RESET_CYCLES        = 10;
   localparam int RANDOM_PHASES       = 10;
   localparam int ITEMS_PER_PHASE     = 125;
   localparam int QUIET_CYCLES        = 4;
   localparam int FINAL_CYCLES        = 60;
   localparam int HOLD_AFTER_RESULTS  = 300;
   localparam int HOLD_CYCLES         = 250;
   localparam int TIMEOUT_CYCLES      = 1_000_000;

   localparam longint LEVEL_TOP    = (longint'(1) <<< (LEVEL_BITS - 1)) - 1;
   localparam longint LEVEL_BOTTOM = -LEVEL_TOP - 1;

   localparam logic signed [VALUE_BITS-1:0] TOP_VALUE    = 24'sh7FFFFF;
   localparam logic signed [VALUE_BITS-1:0] BOTTOM_VALUE = -24'sh800000;

   // one result transaction
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] sample;
      logic                         smoothing;
      logic [SETTLE_BITS-1:0]       steps_left;
      logic signed [VALUE_BITS-1:0] target_now;
   } smoother_result_type;

   localparam smoother_result_type UNCHECKED = '0;

   typedef enum bit [1:0] {
      ROW_ITEM,
      ROW_TYPED,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      row_kind_type                 kind;
      csr_index_type                index;
      logic [CSR_DATA_BITS-1:0]     wdata;
      command_type                  cmd;
      logic signed [VALUE_BITS-1:0] value;
      smoother_result_type          result;
   } directed_row_type;

   // directed stimulus; typed rows carry a hand-written expectation
   directed_row_type directed_plan [33] = '{
      // reset setting: one-tick ramps between the extremes
      '{ROW_TYPED, CSR_MODE, 20'd0, CMD_TICK, 24'sd0, '{24'sd0, 1'b0, 20'd0, 24'sd0}},
      '{ROW_TYPED, CSR_MODE, 20'd0, CMD_JUMP, TOP_VALUE,
        '{TOP_VALUE, 1'b1, 20'd1, TOP_VALUE}},
      '{ROW_TYPED, CSR_MODE, 20'd0, CMD_TICK, 24'sd0,
        '{TOP_VALUE, 1'b0, 20'd0, TOP_VALUE}},
      '{ROW_TYPED, CSR_MODE, 20'd0, CMD_JUMP, BOTTOM_VALUE,
        '{BOTTOM_VALUE, 1'b1, 20'd1, BOTTOM_VALUE}},
      // full-range slope saturates
      '{ROW_TYPED, CSR_MODE, 20'd0, CMD_SET_TARGET, TOP_VALUE,
        '{BOTTOM_VALUE, 1'b1, 20'd1, TOP_VALUE}},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_TYPED, CSR_MODE, 20'd0, CMD_RESTART, 24'sd0,
        '{TOP_VALUE, 1'b1, 20'd1, TOP_VALUE}},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_SET_TARGET, BOTTOM_VALUE, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_TICK, -24'sd1, UNCHECKED},
      // zero ramp steps report the target at once
      '{ROW_WRITE, CSR_RAMP_STEPS, 20'd0, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_TYPED, CSR_MODE, 20'd0, CMD_SET_TARGET, 24'sh123456,
        '{24'sh123456, 1'b0, 20'd0, 24'sh123456}},
      '{ROW_TYPED, CSR_MODE, 20'd0, CMD_JUMP, -24'sd5, '{-24'sd5, 1'b0, 20'd0, -24'sd5}},
      // longest ramp, upper data bits dropped by the register
      '{ROW_WRITE, CSR_RAMP_STEPS, 20'hFFFFF, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_SET_TARGET, TOP_VALUE, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_TICK, 24'sd0, UNCHECKED},
      // exponential approach with the largest coefficient and settle count
      '{ROW_WRITE, CSR_MODE, 20'd1, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_WRITE, CSR_DECAY_COEF, 20'h0FFFF, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_WRITE, CSR_SETTLE_STEPS, 20'hFFFFF, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_SET_TARGET, BOTTOM_VALUE, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_JUMP, 24'sd1, UNCHECKED},
      // exponential mode with no settle count
      '{ROW_WRITE, CSR_SETTLE_STEPS, 20'd0, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_TYPED, CSR_MODE, 20'd0, CMD_SET_TARGET, 24'sd100,
        '{24'sd100, 1'b0, 20'd0, 24'sd100}},
      '{ROW_TYPED, CSR_MODE, 20'd0, CMD_TICK, 24'sd0, '{24'sd100, 1'b0, 20'd0, 24'sd100}},
      // zero coefficient holds the value while counting
      '{ROW_WRITE, CSR_DECAY_COEF, 20'd0, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_WRITE, CSR_SETTLE_STEPS, 20'd3, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_SET_TARGET, -24'sd100, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_TICK, 24'sd0, UNCHECKED},
      // mode change while counting keeps the held countdown
      '{ROW_WRITE, CSR_MODE, 20'd0, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_TICK, 24'sd0, UNCHECKED},
      '{ROW_ITEM, CSR_MODE, 20'd0, CMD_RESTART, 24'sd0, UNCHECKED}
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   command_type                  req_command = CMD_TICK;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [VALUE_BITS-1:0] rsp_sample;
   logic                         rsp_smoothing;
   logic [SETTLE_BITS-1:0]       rsp_steps_left;
   logic signed [VALUE_BITS-1:0] rsp_target_now;
   logic                         csr_write = 1'b0;
   csr_index_type                csr_index = CSR_MODE;
   logic [CSR_DATA_BITS-1:0]     csr_wdata = '0;

   smoother_result_type expected_results [$];
   int  failures     = 0;
   int  results_seen = 0;
   bit  pacing_on    = 1'b1;
   bit  held_off     = 1'b0;

   // smoother settings and state as the block should hold them
   bit                     exp_mode   = 1'b0;
   logic [RAMP_BITS-1:0]   ramp_len   = 16'd1;
   logic [COEF_BITS-1:0]   decay_coef = '0;
   logic [SETTLE_BITS-1:0] settle_len = '0;
   longint                 level      = 0;
   longint                 goal       = 0;
   longint                 slope      = 0;
   logic [SETTLE_BITS-1:0] steps_to_go = '0;

   parameter_ramp_smoother #(
      .VALUE_BITS          (VALUE_BITS),
      .EXTRA_FRACTION_BITS (EXTRA_FRACTION_BITS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample     (rsp_sample),
      .rsp_smoothing  (rsp_smoothing),
      .rsp_steps_left (rsp_steps_left),
      .rsp_target_now (rsp_target_now),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic longint clamp_level(input longint x);
      if (x > LEVEL_TOP) return LEVEL_TOP;
      if (x < LEVEL_BOTTOM) return LEVEL_BOTTOM;
      return x;
   endfunction

   // apply one command to the smoother state and form its result
   function automatic smoother_result_type advance_smoother(
      input command_type cmd,
      input logic signed [VALUE_BITS-1:0] value);
      longint              v;
      longint              delta;
      bit                  stepped;
      smoother_result_type r;
      v = longint'(value);
      stepped = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (steps_to_go != 0) begin
               if (exp_mode) begin
                  delta = (goal <<< EXTRA_FRACTION_BITS) - level;
                  level = clamp_level(level + ((delta * longint'(decay_coef)) >>> COEF_BITS));
               end else begin
                  level = clamp_level(level + slope);
               end
               steps_to_go = steps_to_go - 1'b1;
               stepped = 1'b1;
            end
         end
         CMD_SET_TARGET: begin
            if (exp_mode || ramp_len == 0)
               slope = 0;
            else
               slope = clamp_level(((v <<< EXTRA_FRACTION_BITS) - level) / longint'(ramp_len));
            steps_to_go = exp_mode ? settle_len : SETTLE_BITS'(ramp_len);
            goal = v;
         end
         default: begin
            // jump takes the new value, restart reuses the held target
            if (cmd == CMD_JUMP)
               goal = v;
            level = goal <<< EXTRA_FRACTION_BITS;
            slope = 0;
            steps_to_go = exp_mode ? settle_len : SETTLE_BITS'(ramp_len);
         end
      endcase
      if (stepped || steps_to_go != 0)
         r.sample = VALUE_BITS'(level >>> EXTRA_FRACTION_BITS);
      else
         r.sample = VALUE_BITS'(goal);
      r.smoothing  = (steps_to_go != 0);
      r.steps_left = steps_to_go;
      r.target_now = VALUE_BITS'(goal);
      return r;
   endfunction

   // offer one transaction, with an optional idle burst ahead of it
   task automatic offer_transaction(input command_type cmd,
                                    input logic signed [VALUE_BITS-1:0] value,
                                    input bit typed, input smoother_result_type typed_result);
      smoother_result_type predicted;
      int                  gap;
      if (pacing_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = advance_smoother(cmd, value);
      expected_results.push_back(typed ? typed_result : predicted);
   endtask

   // stop offering and wait for every pending result
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_MODE:         exp_mode   = data[0];
         CSR_RAMP_STEPS:   ramp_len   = data[RAMP_BITS-1:0];
         CSR_DECAY_COEF:   decay_coef = data[COEF_BITS-1:0];
         CSR_SETTLE_STEPS: settle_len = data[SETTLE_BITS-1:0];
         default: ;
      endcase
   endtask

   // main stimulus: directed table, then random phases with fresh settings
   initial begin : stimulus
      command_type                  cmd;
      logic signed [VALUE_BITS-1:0] value;
      logic [RAMP_BITS-1:0]         ramp_pick;
      logic [COEF_BITS-1:0]         coef_pick;
      logic [SETTLE_BITS-1:0]       settle_pick;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            drain_results();
            write_register(directed_plan[i].index, directed_plan[i].wdata);
         end else begin
            offer_transaction(directed_plan[i].cmd, directed_plan[i].value,
                              directed_plan[i].kind == ROW_TYPED, directed_plan[i].result);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         case ($urandom_range(0, 7))
            0:       ramp_pick = '0;
            1:       ramp_pick = '1;
            2:       ramp_pick = RAMP_BITS'($urandom);
            default: ramp_pick = RAMP_BITS'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 5))
            0:       coef_pick = '0;
            1:       coef_pick = '1;
            default: coef_pick = COEF_BITS'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0:       settle_pick = '0;
            1:       settle_pick = '1;
            2:       settle_pick = SETTLE_BITS'($urandom);
            default: settle_pick = SETTLE_BITS'($urandom_range(1, 12));
         endcase
         // upper data bits are random so the register widths get exercised
         write_register(CSR_MODE, {(CSR_DATA_BITS-1)'($urandom), 1'(phase[0] ^ $urandom)});
         write_register(CSR_RAMP_STEPS, {4'($urandom), ramp_pick});
         write_register(CSR_DECAY_COEF, {4'($urandom), coef_pick});
         write_register(CSR_SETTLE_STEPS, settle_pick);
         // last phase runs with no idling on either side
         pacing_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            case ($urandom_range(0, 7))
               0, 1:    cmd = CMD_SET_TARGET;
               2:       cmd = CMD_JUMP;
               3:       cmd = CMD_RESTART;
               default: cmd = CMD_TICK;
            endcase
            case ($urandom_range(0, 7))
               0:       value = TOP_VALUE;
               1:       value = BOTTOM_VALUE;
               2, 3:    value = VALUE_BITS'($urandom_range(0, 2000)) - VALUE_BITS'(1000);
               default: value = VALUE_BITS'($urandom);
            endcase
            offer_transaction(cmd, value, 1'b0, UNCHECKED);
         end
      end

      drain_results();
      repeat (FINAL_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("parameter_ramp_smoother: match");
      else
         $display("parameter_ramp_smoother: mismatch");
      $finish;
   end

   // result side stalls: random bursts and one long hold-off
   initial begin : result_pacing
      int burst;
      forever begin
         @(posedge clock);
         if (!held_off && results_seen >= HOLD_AFTER_RESULTS) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (pacing_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each delivered transaction with the oldest expectation
   always @(posedge clock) begin : result_check
      smoother_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $error("result with no transaction pending: sample %0d", rsp_sample);
            failures++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_sample !== want.sample) begin
               $error("sample: expected %0d, got %0d", want.sample, rsp_sample);
               failures++;
            end
            if (rsp_smoothing !== want.smoothing) begin
               $error("smoothing: expected %0d, got %0d", want.smoothing, rsp_smoothing);
               failures++;
            end
            if (rsp_steps_left !== want.steps_left) begin
               $error("steps_left: expected %0d, got %0d", want.steps_left, rsp_steps_left);
               failures++;
            end
            if (rsp_target_now !== want.target_now) begin
               $error("target_now: expected %0d, got %0d", want.target_now, rsp_target_now);
               failures++;
            end
         end
      end
   end

   // run limit
   initial begin : watchdog
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("parameter_ramp_smoother: mismatch");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/prs_pkg.sv
rtl/parameter_ramp_smoother.sv
tb/parameter_ramp_smoother_test.sv
